// File: sv/lsm2_pkg.sv
// ----------------------------------------------------------------------------
// lsm2_pkg
// Shared widths, types and constants of the 2-D multilateration solver.
// ----------------------------------------------------------------------------
package lsm2_pkg;

   localparam int REG_W     = 16;
   localparam int RANGE_W   = 16;
   localparam int POS_W     = 32;
   localparam int NUM_ANCH  = 4;
   localparam int NUM_ROWS  = NUM_ANCH - 1;
   localparam int CSR_IDX_W = 3;

   // Intermediate widths, each the exact growth of the step that forms it.
   localparam int DIFF_W = REG_W + 1;
   localparam int DSQ_W  = 2 * RANGE_W;
   localparam int C_W    = DSQ_W + 2;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int S_W    = SQ_W + 2;
   localparam int PU_W   = DIFF_W + C_W;
   localparam int U_W    = PU_W + 2;
   localparam int DET_W  = 2 * S_W + 1;
   localparam int NUM_W  = S_W + U_W + 1;
   localparam int QUO_W  = POS_W;

   localparam int FRONT_LAT           = 7;
   // A slot returns via the queue and credit registers after the front pipeline
   // drains, so this many credits keep the input open every cycle, stalls aside.
   localparam int FIFO_DEPTH_DEF      = FRONT_LAT + 2;
   localparam int COORD_FRAC_BITS_DEF = 8;

   localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANCHOR1_X = 3'd0,
      CSR_ANCHOR1_Y = 3'd1,
      CSR_ANCHOR2_X = 3'd2,
      CSR_ANCHOR2_Y = 3'd3,
      CSR_ANCHOR3_X = 3'd4,
      CSR_ANCHOR3_Y = 3'd5,
      CSR_ANCHOR4_X = 3'd6,
      CSR_ANCHOR4_Y = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [REG_W-1:0] x;
      logic signed [REG_W-1:0] y;
   } anchor_type;

   typedef anchor_type [NUM_ANCH-1:0] anchor_set_type;

   localparam anchor_set_type ANCHOR_RESET = '{
      3: '{x: 16'sd0,   y: 16'sd256},
      2: '{x: 16'sd0,   y: 16'sd0},
      1: '{x: 16'sd384, y: 16'sd256},
      0: '{x: 16'sd384, y: 16'sd0}
   };

   typedef struct packed {
      logic [RANGE_W-1:0] range_one;
      logic [RANGE_W-1:0] range_two;
      logic [RANGE_W-1:0] range_three;
      logic [RANGE_W-1:0] range_four;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    singular;
      logic                    clipped;
   } rsp_type;

   // Solved system handed from the front end to the divider back end.
   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [DET_W-1:0] det;
      logic                    singular;
   } sol_type;

endpackage

// File: sv/lsm2_stream_if.sv
// ----------------------------------------------------------------------------
// lsm2_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lsm2_stream_if #(
   parameter type PAYLOAD_type = logic
) ();
   logic        valid;
   logic        ready;
   PAYLOAD_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/least_squares_multilateration_2d_core.sv
// ----------------------------------------------------------------------------
// least_squares_multilateration_2d_core
// 2-D position fix from four anchor ranges by linear least squares.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries four unsigned ranges per transaction; rsp_if returns
//   pos_x/pos_y in signed Q16.16 with singular and clipped flags. Anchor
//   coordinates are written through csr_we/csr_index/csr_wdata while no
//   fix is in flight.
// Throughput: one fix per cycle, sustained while the receiver takes every
//   result. A front pipeline of 7 stages forms A^T A, twice A^T b and the Cramer
//   numerators; a 35-stage back pipeline runs one restoring-division stage
//   per quotient bit, both coordinates side by side.
// Stalls: the front pipeline never stops. A queue of QUEUE_DEPTH entries
//   decouples it from the back end, and req_if.ready drops only when every
//   queue slot is already promised to a fix in flight. A stalled receiver
//   freezes the back end; the output register holds its result.
// Reset: synchronous; clears the pipelines and queue, and loads the anchors
//   with their default layout. req_if.ready is high in the cycle after.
// ----------------------------------------------------------------------------
module least_squares_multilateration_2d_core import lsm2_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH     = FIFO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lsm2_stream_if.sink          req_if,
   lsm2_stream_if.source        rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);
   localparam int CRD_W = $clog2(QUEUE_DEPTH + 1);

   anchor_set_type   anchors_ff, anchors_in;
   logic [CRD_W-1:0] credit_ff, credit_in;
   logic             accept;
   logic             front_valid;
   sol_type          front_sol;
   sol_type          q_data;
   logic             q_empty;
   logic             back_take;

   always_comb begin
      anchors_in = anchors_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ANCHOR1_X: anchors_in[0].x = csr_wdata;
            CSR_ANCHOR1_Y: anchors_in[0].y = csr_wdata;
            CSR_ANCHOR2_X: anchors_in[1].x = csr_wdata;
            CSR_ANCHOR2_Y: anchors_in[1].y = csr_wdata;
            CSR_ANCHOR3_X: anchors_in[2].x = csr_wdata;
            CSR_ANCHOR3_Y: anchors_in[2].y = csr_wdata;
            CSR_ANCHOR4_X: anchors_in[3].x = csr_wdata;
            CSR_ANCHOR4_Y: anchors_in[3].y = csr_wdata;
            default:       anchors_in = anchors_ff;
         endcase
      end
   end

   // Each accepted transaction holds a queue slot until the back end takes it.
   assign accept    = req_if.valid && req_if.ready;
   assign credit_in = credit_ff - CRD_W'(accept) + CRD_W'(back_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         anchors_ff <= ANCHOR_RESET;
         credit_ff  <= CRD_W'(QUEUE_DEPTH);
      end else begin
         anchors_ff <= anchors_in;
         credit_ff  <= credit_in;
      end
   end

   assign req_if.ready = (credit_ff != '0);

   lsm2_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_if.payload),
      .anchors   (anchors_ff),
      .out_valid (front_valid),
      .out_sol   (front_sol)
   );

   lsm2_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_sol),
      .pop       (back_take),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   lsm2_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_sol    (q_data),
      .in_take   (back_take),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_rsp   (rsp_if.payload)
   );
endmodule

// File: sv/lsm2_mul.sv
// ----------------------------------------------------------------------------
// lsm2_mul
// Signed multiplier built from four registered partial products and a registered sum.
// ----------------------------------------------------------------------------
module lsm2_mul #(
   parameter int WA = 36,
   parameter int WB = 36
) (
   input  logic                    clock,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);
   localparam int LO = 32;
   localparam int AH = WA - LO;
   localparam int BH = WB - LO;
   localparam int WP = WA + WB;

   logic signed [LO:0]        a_lo, b_lo;
   logic signed [AH-1:0]      a_hi;
   logic signed [BH-1:0]      b_hi;
   logic signed [2*LO+1:0]    pll_ff;
   logic signed [LO+BH:0]     plh_ff;
   logic signed [AH+LO:0]     phl_ff;
   logic signed [AH+BH-1:0]   phh_ff;
   logic signed [WP-1:0]      p_ff, p_in;

   // Low halves get a zero sign bit so every product is a signed one.
   assign a_lo = $signed({1'b0, a[LO-1:0]});
   assign b_lo = $signed({1'b0, b[LO-1:0]});
   assign a_hi = a[WA-1:LO];
   assign b_hi = b[WB-1:LO];

   always_comb begin
      p_in = (WP'(phh_ff) <<< (2 * LO)) + (WP'(plh_ff) <<< LO)
           + (WP'(phl_ff) <<< LO) + WP'(pll_ff);
   end

   always_ff @(posedge clock) begin
      pll_ff <= a_lo * b_lo;
      plh_ff <= a_lo * b_hi;
      phl_ff <= a_hi * b_lo;
      phh_ff <= a_hi * b_hi;
      p_ff   <= p_in;
   end

   assign p = p_ff;
endmodule

// File: sv/lsm2_front.sv
// ----------------------------------------------------------------------------
// lsm2_front
// Builds the normal equations and the Cramer numerators for one range set.
// ----------------------------------------------------------------------------
module lsm2_front import lsm2_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  req_type        in_req,
   input  anchor_set_type anchors,
   output logic           out_valid,
   output sol_type        out_sol
);
   logic [FRONT_LAT-1:0] vld_ff, vld_in;

   logic [RANGE_W-1:0]        rng [NUM_ANCH];
   logic signed [2*REG_W-1:0] sqx [NUM_ANCH];
   logic signed [2*REG_W-1:0] sqy [NUM_ANCH];

   logic [DSQ_W-1:0]          dsq1_ff [NUM_ANCH], dsq1_in [NUM_ANCH];
   logic [DSQ_W-1:0]          nsq1_ff [NUM_ANCH], nsq1_in [NUM_ANCH];
   logic signed [DIFF_W-1:0]  ax1_ff [NUM_ROWS], ax1_in [NUM_ROWS];
   logic signed [DIFF_W-1:0]  ay1_ff [NUM_ROWS], ay1_in [NUM_ROWS];

   logic signed [C_W-1:0]     c2_ff [NUM_ROWS], c2_in [NUM_ROWS];
   logic signed [SQ_W-1:0]    xx2_ff [NUM_ROWS], xx2_in [NUM_ROWS];
   logic signed [SQ_W-1:0]    xy2_ff [NUM_ROWS], xy2_in [NUM_ROWS];
   logic signed [SQ_W-1:0]    yy2_ff [NUM_ROWS], yy2_in [NUM_ROWS];
   logic signed [DIFF_W-1:0]  ax2_ff [NUM_ROWS], ay2_ff [NUM_ROWS];

   logic signed [PU_W-1:0]    pu1_ff [NUM_ROWS], pu1_in [NUM_ROWS];
   logic signed [PU_W-1:0]    pu2_ff [NUM_ROWS], pu2_in [NUM_ROWS];
   logic signed [S_W-1:0]     s11_3_ff, s12_3_ff, s22_3_ff;
   logic signed [S_W-1:0]     s11_3_in, s12_3_in, s22_3_in;

   logic signed [U_W-1:0]     u1_4_ff, u2_4_ff, u1_4_in, u2_4_in;
   logic signed [S_W-1:0]     s11_4_ff, s12_4_ff, s22_4_ff;

   logic signed [2*S_W-1:0]   m_dp, m_dn;
   logic signed [S_W+U_W-1:0] m_xp, m_xn, m_yp, m_yn;

   sol_type sol_ff, sol_in;

   assign rng[0] = in_req.range_one;
   assign rng[1] = in_req.range_two;
   assign rng[2] = in_req.range_three;
   assign rng[3] = in_req.range_four;

   // Stage 1: squared ranges, squared anchor norms and the rows of A.
   always_comb begin
      for (int i = 0; i < NUM_ANCH; i++) begin
         dsq1_in[i] = DSQ_W'(rng[i]) * DSQ_W'(rng[i]);
         sqx[i]     = anchors[i].x * anchors[i].x;
         sqy[i]     = anchors[i].y * anchors[i].y;
         nsq1_in[i] = unsigned'(sqx[i]) + unsigned'(sqy[i]);
      end
      for (int i = 0; i < NUM_ROWS; i++) begin
         ax1_in[i] = DIFF_W'(anchors[i+1].x) - DIFF_W'(anchors[0].x);
         ay1_in[i] = DIFF_W'(anchors[i+1].y) - DIFF_W'(anchors[0].y);
      end
   end

   // Stage 2: right-hand side (twice b) and the element products of A^T A.
   always_comb begin
      for (int i = 0; i < NUM_ROWS; i++) begin
         c2_in[i]  = C_W'(dsq1_ff[0]) - C_W'(dsq1_ff[i+1])
                   + C_W'(nsq1_ff[i+1]) - C_W'(nsq1_ff[0]);
         xx2_in[i] = SQ_W'(ax1_ff[i] * ax1_ff[i]);
         xy2_in[i] = SQ_W'(ax1_ff[i] * ay1_ff[i]);
         yy2_in[i] = SQ_W'(ay1_ff[i] * ay1_ff[i]);
      end
   end

   // Stage 3: A^T A sums and the element products of A^T c.
   always_comb begin
      for (int i = 0; i < NUM_ROWS; i++) begin
         pu1_in[i] = PU_W'(ax2_ff[i] * c2_ff[i]);
         pu2_in[i] = PU_W'(ay2_ff[i] * c2_ff[i]);
      end
      s11_3_in = S_W'(xx2_ff[0]) + S_W'(xx2_ff[1]) + S_W'(xx2_ff[2]);
      s12_3_in = S_W'(xy2_ff[0]) + S_W'(xy2_ff[1]) + S_W'(xy2_ff[2]);
      s22_3_in = S_W'(yy2_ff[0]) + S_W'(yy2_ff[1]) + S_W'(yy2_ff[2]);
   end

   // Stage 4: A^T c sums.
   always_comb begin
      u1_4_in = U_W'(pu1_ff[0]) + U_W'(pu1_ff[1]) + U_W'(pu1_ff[2]);
      u2_4_in = U_W'(pu2_ff[0]) + U_W'(pu2_ff[1]) + U_W'(pu2_ff[2]);
   end

   // Stages 5 and 6: the six cross products of the 2x2 Cramer solve.
   lsm2_mul #(.WA(S_W), .WB(S_W)) u_mul_dp (
      .clock(clock), .a(s11_4_ff), .b(s22_4_ff), .p(m_dp));
   lsm2_mul #(.WA(S_W), .WB(S_W)) u_mul_dn (
      .clock(clock), .a(s12_4_ff), .b(s12_4_ff), .p(m_dn));
   lsm2_mul #(.WA(S_W), .WB(U_W)) u_mul_xp (
      .clock(clock), .a(s22_4_ff), .b(u1_4_ff), .p(m_xp));
   lsm2_mul #(.WA(S_W), .WB(U_W)) u_mul_xn (
      .clock(clock), .a(s12_4_ff), .b(u2_4_ff), .p(m_xn));
   lsm2_mul #(.WA(S_W), .WB(U_W)) u_mul_yp (
      .clock(clock), .a(s11_4_ff), .b(u2_4_ff), .p(m_yp));
   lsm2_mul #(.WA(S_W), .WB(U_W)) u_mul_yn (
      .clock(clock), .a(s12_4_ff), .b(u1_4_ff), .p(m_yn));

   // Stage 7: determinant, numerators and the singular-geometry flag.
   always_comb begin
      sol_in.det      = DET_W'(m_dp) - DET_W'(m_dn);
      sol_in.num_x    = NUM_W'(m_xp) - NUM_W'(m_xn);
      sol_in.num_y    = NUM_W'(m_yp) - NUM_W'(m_yn);
      sol_in.singular = (m_dp == m_dn);
   end

   assign vld_in = {vld_ff[FRONT_LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dsq1_ff  <= dsq1_in;
      nsq1_ff  <= nsq1_in;
      ax1_ff   <= ax1_in;
      ay1_ff   <= ay1_in;
      c2_ff    <= c2_in;
      xx2_ff   <= xx2_in;
      xy2_ff   <= xy2_in;
      yy2_ff   <= yy2_in;
      ax2_ff   <= ax1_ff;
      ay2_ff   <= ay1_ff;
      pu1_ff   <= pu1_in;
      pu2_ff   <= pu2_in;
      s11_3_ff <= s11_3_in;
      s12_3_ff <= s12_3_in;
      s22_3_ff <= s22_3_in;
      u1_4_ff  <= u1_4_in;
      u2_4_ff  <= u2_4_in;
      s11_4_ff <= s11_3_ff;
      s12_4_ff <= s12_3_ff;
      s22_4_ff <= s22_3_ff;
      sol_ff   <= sol_in;
   end

   assign out_valid = vld_ff[FRONT_LAT-1];
   assign out_sol   = sol_ff;
endmodule

// File: sv/lsm2_fifo.sv
// ----------------------------------------------------------------------------
// lsm2_fifo
// Short register queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module lsm2_fifo import lsm2_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  sol_type push_data,
   input  logic    pop,
   output sol_type pop_data,
   output logic    empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sol_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (cnt_ff == '0);
endmodule

// File: sv/lsm2_back.sv
// ----------------------------------------------------------------------------
// lsm2_back
// Pipelined restoring divider, rounding and saturation for both coordinates.
// ----------------------------------------------------------------------------
module lsm2_back import lsm2_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  sol_type in_sol,
   output logic    in_take,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);
   localparam int SHIFT = REG_W - COORD_FRAC_BITS;
   localparam int DM_W  = DET_W + 1;
   localparam int D_W   = DET_W + 2;
   localparam int NW    = NUM_W + SHIFT + 2;
   localparam int CW    = (NW > D_W + QUO_W) ? NW : D_W + QUO_W;
   localparam int NSTG  = QUO_W + 2;

   typedef struct packed {
      logic [CW-1:0]    rem;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } lane_type;

   typedef struct packed {
      lane_type         lx;
      lane_type         ly;
      logic [D_W-1:0]   dvs;
      logic             sing;
   } stg_type;

   typedef struct packed {
      logic [POS_W-1:0] val;
      logic             clip;
   } sat_type;

   logic             en;
   logic             det_neg;
   logic [DET_W-1:0] det_mag;
   logic [NSTG-1:0]  vld_ff;
   stg_type          stg_ff [NSTG];
   stg_type          stg_in [NSTG];
   logic             out_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   sat_type          sat_x, sat_y;

   // The rounded quotient is floor((2*|n|*2^SHIFT + |2det|) / (2*|2det|)).
   function automatic lane_type prep(logic signed [NUM_W-1:0] num, logic dneg,
                                     logic [DM_W-1:0] dm);
      logic [NUM_W-1:0] mag;
      lane_type         l;
      mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      l.rem = CW'((NW'(mag) << (SHIFT + 1)) + NW'(dm));
      l.quo = '0;
      l.ovf = 1'b0;
      l.neg = num[NUM_W-1] ^ dneg;
      return l;
   endfunction

   // A quotient of 2^32 or more saturates in either direction.
   function automatic lane_type ovf_chk(lane_type l, logic [D_W-1:0] dvs);
      lane_type r;
      r     = l;
      r.ovf = (l.rem >= (CW'(dvs) << QUO_W));
      return r;
   endfunction

   function automatic lane_type bit_step(lane_type l, logic [D_W-1:0] dvs, int k);
      logic [CW-1:0] dk;
      lane_type      r;
      r  = l;
      dk = CW'(dvs) << k;
      if (l.rem >= dk) begin
         r.quo[k] = 1'b1;
         r.rem    = l.rem - dk;
      end
      return r;
   endfunction

   function automatic sat_type saturate(lane_type l);
      sat_type s;
      if (l.neg) begin
         if (l.ovf || (l.quo > POS_MIN)) begin
            s.val  = POS_MIN;
            s.clip = 1'b1;
         end else begin
            s.val  = -l.quo;
            s.clip = 1'b0;
         end
      end else begin
         if (l.ovf || l.quo[QUO_W-1]) begin
            s.val  = POS_MAX;
            s.clip = 1'b1;
         end else begin
            s.val  = l.quo;
            s.clip = 1'b0;
         end
      end
      return s;
   endfunction

   assign en      = !out_valid_ff || out_ready;
   assign in_take = en && in_valid;
   assign det_neg = in_sol.det[DET_W-1];
   assign det_mag = det_neg ? DET_W'(-in_sol.det) : DET_W'(in_sol.det);

   always_comb begin
      stg_in[0].lx   = prep(in_sol.num_x, det_neg, {det_mag, 1'b0});
      stg_in[0].ly   = prep(in_sol.num_y, det_neg, {det_mag, 1'b0});
      stg_in[0].dvs  = {det_mag, 2'b00};
      stg_in[0].sing = in_sol.singular;
      stg_in[1]      = stg_ff[0];
      stg_in[1].lx   = ovf_chk(stg_ff[0].lx, stg_ff[0].dvs);
      stg_in[1].ly   = ovf_chk(stg_ff[0].ly, stg_ff[0].dvs);
      // One quotient bit per stage, most significant first.
      for (int j = 2; j < NSTG; j++) begin
         stg_in[j]    = stg_ff[j-1];
         stg_in[j].lx = bit_step(stg_ff[j-1].lx, stg_ff[j-1].dvs, NSTG - 1 - j);
         stg_in[j].ly = bit_step(stg_ff[j-1].ly, stg_ff[j-1].dvs, NSTG - 1 - j);
      end
   end

   always_comb begin
      sat_x = saturate(stg_ff[NSTG-1].lx);
      sat_y = saturate(stg_ff[NSTG-1].ly);
      if (stg_ff[NSTG-1].sing) begin
         rsp_in.pos_x    = '0;
         rsp_in.pos_y    = '0;
         rsp_in.singular = 1'b1;
         rsp_in.clipped  = 1'b0;
      end else begin
         rsp_in.pos_x    = sat_x.val;
         rsp_in.pos_y    = sat_y.val;
         rsp_in.singular = 1'b0;
         rsp_in.clipped  = sat_x.clip | sat_y.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NSTG-2:0], in_valid};
         out_valid_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff <= stg_in;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;
endmodule

// File: sv/lsm2_chk.sv
// ----------------------------------------------------------------------------
// lsm2_chk
// Port-level checks of the multilateration core, bound to its top level.
// ----------------------------------------------------------------------------
module lsm2_chk import lsm2_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or vanished while stalled");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.singular |->
         rsp_payload.pos_x == '0 && rsp_payload.pos_y == '0 && !rsp_payload.clipped)
      else $error("singular result with nonzero position or clip flag");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.clipped |->
         rsp_payload.pos_x == POS_MAX || rsp_payload.pos_x == POS_MIN ||
         rsp_payload.pos_y == POS_MAX || rsp_payload.pos_y == POS_MIN)
      else $error("clipped result with no coordinate on a rail");

   a_reset_state: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("core not empty and ready after reset");
endmodule

bind least_squares_multilateration_2d_core lsm2_chk u_lsm2_chk (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2-D least-squares multilateration core.
// A built-in solver predicts each position fix from the range set and the
// current anchor layout. Every returned fix is compared field by field.
// The run covers several anchor layouts, including extreme and collinear
// ones, and varies the idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import lsm2_pkg::*;

   localparam int  FRAC_BITS   = COORD_FRAC_BITS_DEF;
   localparam int  PRE_SHIFT   = 16 - FRAC_BITS;
   localparam int  SETTLE      = 60;
   localparam int  CYCLE_LIMIT = 400000;

   typedef logic signed [127:0] wide_type;
   typedef logic [REG_W-1:0] layout_type [2*NUM_ANCH];

   class fix_scoreboard;
      logic signed [REG_W-1:0] anchor_reg [2*NUM_ANCH];
      rsp_type                 pending_fixes [$];
      int                      errors;
      int                      fixes_checked;
      int                      singular_seen;
      int                      clipped_seen;

      function void set_anchor(csr_idx_type idx, logic [REG_W-1:0] val);
         anchor_reg[idx] = val;
      endfunction

      // Rounds num/den2 to Q16.16 with ties away from zero, then saturates.
      function logic [POS_W-1:0] round_coord(wide_type num, wide_type den2,
                                             ref logic clip);
         logic        neg;
         logic [127:0] nm, dm, q;
         neg = num[127] ^ den2[127];
         nm  = num[127] ? -num : num;
         dm  = den2[127] ? -den2 : den2;
         nm  = nm << PRE_SHIFT;
         q   = ((nm << 1) + dm) / (dm << 1);
         if (neg) begin
            if (q > 128'h8000_0000) begin
               clip = 1'b1;
               return POS_MIN;
            end
            return -q[POS_W-1:0];
         end
         if (q > 128'h7FFF_FFFF) begin
            clip = 1'b1;
            return POS_MAX;
         end
         return q[POS_W-1:0];
      endfunction

      function rsp_type solve_fix(req_type r);
         longint   px [NUM_ANCH], py [NUM_ANCH], dsq [NUM_ANCH];
         longint   ax, ay, c, n1, s11, s12, s22, u1, u2;
         wide_type w11, w12, w22, wu1, wu2, det, nx, ny;
         logic     clip;
         rsp_type  fix;
         dsq[0] = longint'(r.range_one) * longint'(r.range_one);
         dsq[1] = longint'(r.range_two) * longint'(r.range_two);
         dsq[2] = longint'(r.range_three) * longint'(r.range_three);
         dsq[3] = longint'(r.range_four) * longint'(r.range_four);
         for (int i = 0; i < NUM_ANCH; i++) begin
            px[i] = anchor_reg[2*i];
            py[i] = anchor_reg[2*i+1];
         end
         n1 = px[0]*px[0] + py[0]*py[0];
         s11 = 0; s12 = 0; s22 = 0; u1 = 0; u2 = 0;
         for (int i = 1; i < NUM_ANCH; i++) begin
            ax = px[i] - px[0];
            ay = py[i] - py[0];
            c  = dsq[0] - dsq[i] + px[i]*px[i] + py[i]*py[i] - n1;
            s11 += ax*ax;
            s12 += ax*ay;
            s22 += ay*ay;
            u1  += ax*c;
            u2  += ay*c;
         end
         w11 = s11; w12 = s12; w22 = s22; wu1 = u1; wu2 = u2;
         det = w11*w22 - w12*w12;
         fix = '0;
         if (det == 0) begin
            fix.singular = 1'b1;
            return fix;
         end
         // The right-hand side carries a factor of two, so the divisor does too.
         nx   = w22*wu1 - w12*wu2;
         ny   = w11*wu2 - w12*wu1;
         clip = 1'b0;
         fix.pos_x   = round_coord(nx, det <<< 1, clip);
         fix.pos_y   = round_coord(ny, det <<< 1, clip);
         fix.clipped = clip;
         return fix;
      endfunction

      function void note_request(req_type r);
         pending_fixes.push_back(solve_fix(r));
      endfunction

      function void check_fix(rsp_type got);
         rsp_type want;
         if (pending_fixes.size() == 0) begin
            $display("%0t: unexpected fix x=%h y=%h s=%b c=%b", $time,
                     got.pos_x, got.pos_y, got.singular, got.clipped);
            errors++;
            return;
         end
         want = pending_fixes.pop_front();
         fixes_checked++;
         if (want.singular) singular_seen++;
         if (want.clipped) clipped_seen++;
         if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
            errors++;
         end
         if (got.singular !== want.singular) begin
            $display("%0t: singular expected %b actual %b", $time,
                     want.singular, got.singular);
            errors++;
         end
         if (got.clipped !== want.clipped) begin
            $display("%0t: clipped expected %b actual %b", $time,
                     want.clipped, got.clipped);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   cycle_count;
   int                   fixes_sent;
   fix_scoreboard        board;

   lsm2_stream_if #(.PAYLOAD_type(req_type)) req_if ();
   lsm2_stream_if #(.PAYLOAD_type(rsp_type)) rsp_if ();

   least_squares_multilateration_2d_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("** least_squares_multilateration_2d_core: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_fix(rsp_if.payload);
   end

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic send_ranges(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(r);
      fixes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.pending_fixes.size() != 0);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_layout(layout_type layout);
      for (int i = 0; i < 2*NUM_ANCH; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= layout[i];
         board.set_anchor(csr_idx_type'(i), layout[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type random_ranges();
      req_type r;
      if ($urandom_range(99) < 70) begin
         r.range_one   = 16'($urandom_range(4095));
         r.range_two   = 16'($urandom_range(4095));
         r.range_three = 16'($urandom_range(4095));
         r.range_four  = 16'($urandom_range(4095));
      end else begin
         r = req_type'({$urandom, $urandom});
      end
      return r;
   endfunction

   function automatic layout_type make_layout(int kind);
      layout_type l;
      for (int i = 0; i < 2*NUM_ANCH; i++) begin
         case (kind)
            1, 5: l[i] = 16'($urandom);
            2: l[i] = (i inside {0, 3, 5, 6}) ? 16'h7FFF : 16'h8000;
            3: l[i] = (i % 2 == 1) ? 16'h0000 : 16'($urandom);  // all on the x axis
            4: l[i] = 16'($urandom_range(4095)) - 16'd2048;
            default: l[i] = 16'($urandom);
         endcase
      end
      return l;
   endfunction

   initial begin
      req_type     r;
      layout_type  l;
      board         = new();
      board.anchor_reg = '{16'sd384, 16'sd0, 16'sd384, 16'sd256,
                           16'sd0, 16'sd0, 16'sd0, 16'sd256};
      cycle_count   = 0;
      fixes_sent    = 0;
      send_idle_pct = 31;
      recv_idle_pct = 71;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.payload = '0;
      rsp_if.ready  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets against the reset layout.
      send_ranges('{16'd0, 16'd0, 16'd0, 16'd0});
      send_ranges('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_ranges('{16'hFFFF, 16'd0, 16'd0, 16'd0});
      send_ranges('{16'd0, 16'hFFFF, 16'd0, 16'd0});
      send_ranges('{16'd0, 16'd0, 16'hFFFF, 16'd0});
      send_ranges('{16'd0, 16'd0, 16'd0, 16'hFFFF});
      send_ranges('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
      send_ranges('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
      send_ranges('{16'd256, 16'd256, 16'd384, 16'd384});
      send_ranges('{16'd1, 16'd1, 16'd1, 16'd1});
      for (int i = 0; i < 8; i++) send_ranges(random_ranges());
      drain_pipeline();

      // A collinear layout must flag singular even for extreme ranges.
      load_layout(make_layout(3));
      send_ranges('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
      send_ranges('{16'd100, 16'd200, 16'd300, 16'd400});
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 71 : 0;
         recv_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 31 : 0;
         l = make_layout(phase);
         if (phase == 0) l = '{16'd384, 16'd0, 16'd384, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256};
         load_layout(l);
         for (int i = 0; i < 88; i++) send_ranges(random_ranges());
         drain_pipeline();
      end

      $display("Sent %0d range sets over 8 anchor layouts; %0d fixes checked,", fixes_sent,
               board.fixes_checked);
      $display("%0d singular and %0d clipped, %0d errors.", board.singular_seen,
               board.clipped_seen, board.errors);
      if (board.errors == 0 && board.pending_fixes.size() == 0) begin
         $display("** least_squares_multilateration_2d_core: PASSED **");
      end else begin
         $display("** least_squares_multilateration_2d_core: FAILED **");
      end
      $finish;
   end
endmodule

// File: sim.f
sv/lsm2_pkg.sv
sv/lsm2_stream_if.sv
sv/lsm2_mul.sv
sv/lsm2_front.sv
sv/lsm2_fifo.sv
sv/lsm2_back.sv
sv/least_squares_multilateration_2d_core.sv
sv/lsm2_chk.sv
sim/tb_top.sv
